/* hdl/salfp_pkg.sv */
// Package for the sync-word, length-prefixed frame parser.
// Holds the parse phase type, the result record and the register map.
// Used by salfp_core and sync_addr_len_frame_parser; depends on nothing.
`default_nettype none

package salfp_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned AddrWidth    = 16;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [ByteWidth-1:0] SyncFirstReset  = 8'h5a;
  localparam logic [ByteWidth-1:0] SyncSecondReset = 8'ha5;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SYNC_SECOND = 2'd1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ADDR_H  = 3'd2,
    PH_ADDR_L  = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [AddrWidth-1:0] frame_address;
    logic [ByteWidth-1:0] frame_length;
    logic [ByteWidth-1:0] payload_byte;
    logic                 has_byte;
    logic                 last_of_frame;
  } result_t;

endpackage

`default_nettype wire

/* hdl/salfp_core.sv */
// Frame parsing state machine: phase, address, length and payload count.
// Takes one byte per step and forms the result record combinationally.
// Depends on salfp_pkg.
`default_nettype none

module salfp_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [salfp_pkg::ByteWidth-1:0] in_byte,
  input  wire logic [salfp_pkg::ByteWidth-1:0] sync_first,
  input  wire logic [salfp_pkg::ByteWidth-1:0] sync_second,
  output logic                                emit,
  output salfp_pkg::result_t                  res
);
  import salfp_pkg::*;

  phase_t               phase, phase_next;
  logic [AddrWidth-1:0] address_acc, address_acc_next;
  logic [ByteWidth-1:0] length_reg, length_reg_next;
  logic [ByteWidth-1:0] byte_count, byte_count_next;
  logic [ByteWidth-1:0] count_inc;

  assign count_inc = byte_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      address_acc <= '0;
      length_reg  <= '0;
      byte_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      address_acc <= address_acc_next;
      length_reg  <= length_reg_next;
      byte_count  <= byte_count_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    address_acc_next  = address_acc;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    emit              = 1'b0;
    res.frame_address = address_acc;
    res.frame_length  = length_reg;
    res.payload_byte  = in_byte;
    res.has_byte      = 1'b1;
    res.last_of_frame = 1'b0;
    unique case (phase)
      PH_SYNC2: begin
        // A wrong second byte is not retried as a first sync byte.
        phase_next = (in_byte == sync_second) ? PH_ADDR_H : PH_HUNT;
      end
      PH_ADDR_H: begin
        address_acc_next = {{(AddrWidth-ByteWidth){1'b0}}, in_byte};
        phase_next       = PH_ADDR_L;
      end
      PH_ADDR_L: begin
        address_acc_next = {address_acc[ByteWidth-1:0], in_byte};
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        length_reg_next  = in_byte;
        byte_count_next  = '0;
        res.frame_length = in_byte;
        if (in_byte == '0) begin
          // An empty frame still reports itself, with no data byte.
          emit              = 1'b1;
          res.payload_byte  = '0;
          res.has_byte      = 1'b0;
          res.last_of_frame = 1'b1;
          phase_next        = PH_HUNT;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit              = 1'b1;
        byte_count_next   = count_inc;
        res.last_of_frame = (count_inc >= length_reg);
        if (count_inc >= length_reg) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = (in_byte == sync_first) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_count < length_reg)
    else $error("payload count has reached the declared length");

  a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    step && emit && res.last_of_frame |=> phase == PH_HUNT)
    else $error("parser did not resume hunting after the end of a frame");

  a_payload_exit: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_PAYLOAD |=> phase == PH_PAYLOAD || phase == PH_HUNT)
    else $error("payload phase left for a phase other than hunting");

endmodule

`default_nettype wire

/* hdl/sync_addr_len_frame_parser.sv */
// Sync-word, length-prefixed frame parser. Each received byte is accepted
// on the input channel and, after passing an input register and the parsing
// logic, any result it causes sits in the output register, so a byte is
// taken every cycle while results flow. A frame is two sync bytes
// (registers 0 and 1, reset 0x5a and 0xa5), a 16-bit address high byte
// first, a length byte and that many payload bytes; each payload byte comes
// out tagged with address, length and a last-of-frame mark, and a zero
// length gives one result with has_byte low. Sync values are written
// through the cfg port; the user must do so only while idle, as the block
// itself does not enforce it. Depends on salfp_pkg and salfp_core.
`default_nettype none

module sync_addr_len_frame_parser (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [salfp_pkg::ByteWidth-1:0]   in_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [salfp_pkg::AddrWidth-1:0]       frame_address,
  output logic [salfp_pkg::ByteWidth-1:0]       frame_length,
  output logic [salfp_pkg::ByteWidth-1:0]       payload_byte,
  output logic                                  has_byte,
  output logic                                  last_of_frame,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [salfp_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [salfp_pkg::ByteWidth-1:0]   cfg_data
);
  import salfp_pkg::*;

  logic [ByteWidth-1:0] sync_first, sync_second;
  logic                 in_reg_valid;
  logic [ByteWidth-1:0] in_reg_byte;
  logic                 advance;
  logic                 step;
  logic                 emit;
  result_t              res;
  result_t              out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstReset;
      sync_second <= SyncSecondReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held byte moves on whenever the output register is free or emptying.
  assign advance  = !out_valid || out_ready;
  assign step     = in_reg_valid && advance;
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte <= in_byte;
    end
  end

  salfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .in_byte     (in_reg_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .emit        (emit),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res <= res;
    end
  end

  assign frame_address = out_res.frame_address;
  assign frame_length  = out_res.frame_length;
  assign payload_byte  = out_res.payload_byte;
  assign has_byte      = out_res.has_byte;
  assign last_of_frame = out_res.last_of_frame;

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !advance |=> in_reg_valid && $stable(in_reg_byte))
    else $error("a held byte was lost or changed while the output stalled");

  a_empty_frame_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last_of_frame && payload_byte == '0)
    else $error("an empty-frame result is malformed");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(step && emit) |=> !out_valid)
    else $error("a taken result was shown again");

endmodule

`default_nettype wire
